// ===== design/sha_pkg.sv =====
// SHA-256 package: item types, round constants and round helper functions.
// No dependencies; imported by sha256_hash, sha256_checker and tb_top.
package sha_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned BLK_WORDS = 16;
	localparam int unsigned ROUNDS   = 64;
	localparam int unsigned WIDX_W   = $clog2(BLK_WORDS);
	localparam int unsigned RIDX_W   = $clog2(ROUNDS);
	localparam int unsigned BYTES_W  = 61;
	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [2:0]  FULL_BYTES = 3'd4;

	typedef struct packed {
		logic [31:0] msg_word;
		logic [2:0]  word_bytes;
		logic        last_word;
	} sha_in_t;

	typedef struct packed {
		logic [63:0] digest_0;
		logic [63:0] digest_1;
		logic [63:0] digest_2;
		logic [63:0] digest_3;
	} sha_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_UPDATE,
		ST_PAD,
		ST_DONE
	} sha_state_t;

	typedef logic [31:0] word_t;
	typedef word_t [7:0] hash_t;

	localparam hash_t INIT_HASH = '{
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic word_t round_k(input logic [RIDX_W-1:0] i);
		word_t k;
		case (i)
			6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
			6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
			6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
			6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
			6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (WORD_W - n));
	endfunction

	function automatic word_t sig0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t sig1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(input word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(input word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

// ===== design/sha256_hash.sv =====
// SHA-256 hasher: one 16-word schedule window in flip-flops, one round unit.
// Depends on sha_pkg.
//
// Usage: message words enter on in_valid/in_stall as sha_in_t items, the last
// flagged with its count of valid bytes. An item that completes a block starts
// its compression: 64 rounds (one per cycle, through the single round adder),
// then a fold into the hash. On a last word the padding words are pushed one
// per cycle through the same path, paused while a block compresses (up to 18
// words, plus up to two compressions), then the digest item is offered on
// out_valid and held in its register until out_stall is low.
// in_stall stays high while a block compresses, while padding runs and while
// the digest waits. After the digest is taken the initial hash is back.
// Reset (arst_n low) returns to idle with the initial hash, no word count and
// no digest pending.
module sha256_hash (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sha_pkg::sha_in_t  in_item,
	output logic              out_valid,
	input  logic              out_stall,
	output sha_pkg::sha_out_t out_item
);
	import sha_pkg::*;

	sha_state_t state_q, state_d;
	hash_t      hash_q;
	hash_t      var_q;
	word_t      w_q [BLK_WORDS];
	logic [WIDX_W-1:0]  widx_q;
	logic [RIDX_W-1:0]  ridx_q;
	logic [BYTES_W-1:0] bytes_q;
	logic [1:0]         pad_q;     // 1: 0x80 word, 2: zeros, 3: length
	logic               len_lo_q;
	sha_out_t           out_q;

	logic        accept, push, blk_full;
	word_t       push_word, in_word, pad_word, w_new, t1, t2;
	logic [2:0]  nb;
	logic [63:0] bits;
	logic [BYTES_W-1:0] bytes_add;
	logic [4:0]  sh;
	logic        len_next;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != ST_IDLE;
	assign out_valid = state_q == ST_DONE;
	assign out_item  = out_q;

	assign nb = in_item.last_word
		? ((in_item.word_bytes > FULL_BYTES) ? FULL_BYTES : in_item.word_bytes)
		: FULL_BYTES;
	assign sh = 5'(24 - 8 * nb);
	always_comb begin
		if (nb == FULL_BYTES)
			in_word = in_item.msg_word;
		else if (nb == 3'd0)
			in_word = {PAD_BYTE, 24'd0};
		else
			in_word = (in_item.msg_word & ~(32'hffffffff >> (8 * nb)))
				| (word_t'(PAD_BYTE) << sh);
	end
	assign bits = {bytes_q, 3'b000};
	always_comb begin
		case (pad_q)
			2'd1:    pad_word = {PAD_BYTE, 24'd0};
			2'd3:    pad_word = len_lo_q ? bits[31:0] : bits[63:32];
			default: pad_word = '0;
		endcase
	end

	assign push      = accept || state_q == ST_PAD;
	assign push_word = accept ? in_word : pad_word;
	assign blk_full  = widx_q == WIDX_W'(BLK_WORDS - 1);
	assign bytes_add = BYTES_W'(nb);
	// the length goes straight after this push when it lands in word 13
	assign len_next  = widx_q == WIDX_W'(BLK_WORDS - 3);

	// schedule word for rounds 16 and up, computed from the 16-word window
	assign w_new = w_q[0] + sig0(w_q[1]) + w_q[9] + sig1(w_q[14]);
	assign t1 = var_q[7] + bsig1(var_q[4])
		+ ((var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]))
		+ round_k(ridx_q) + w_q[0];
	assign t2 = bsig0(var_q[0])
		+ ((var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]));

	logic pad_more;
	assign pad_more = !(pad_q == 2'd3 && len_lo_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (blk_full)
						state_d = ST_ROUND;
					else if (in_item.last_word)
						state_d = ST_PAD;
				end
			end
			ST_PAD: begin
				if (blk_full)
					state_d = ST_ROUND;
				else if (!pad_more)
					state_d = ST_DONE;
			end
			ST_ROUND: begin
				if (ridx_q == RIDX_W'(ROUNDS - 1))
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (pad_q == 2'd0)
					state_d = ST_IDLE;
				else if (pad_q == 2'd3 && len_lo_q)
					state_d = ST_DONE;
				else
					state_d = ST_PAD;
			end
			ST_DONE: begin
				if (!out_stall)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			hash_q   <= INIT_HASH;
			var_q    <= '0;
			for (int i = 0; i < BLK_WORDS; i++)
				w_q[i] <= '0;
			widx_q   <= '0;
			ridx_q   <= '0;
			bytes_q  <= '0;
			pad_q    <= 2'd0;
			len_lo_q <= 1'b0;
			out_q    <= '0;
		end else begin
			state_q <= state_d;
			if (push) begin
				w_q[widx_q] <= push_word;
				widx_q <= widx_q + 1'b1;
				if (blk_full)
					var_q <= hash_q;
			end
			if (accept) begin
				bytes_q <= bytes_q + bytes_add;
				if (in_item.last_word)
					pad_q <= (nb == FULL_BYTES) ? 2'd1 : (len_next ? 2'd3 : 2'd2);
			end else if (state_q == ST_PAD) begin
				if (pad_q == 2'd1)
					pad_q <= len_next ? 2'd3 : 2'd2;
				else if (pad_q == 2'd2 && len_next)
					pad_q <= 2'd3;
				else if (pad_q == 2'd3)
					len_lo_q <= 1'b1;
			end
			if (state_q == ST_ROUND) begin
				for (int i = 0; i < BLK_WORDS - 1; i++)
					w_q[i] <= w_q[i + 1];
				w_q[BLK_WORDS - 1] <= w_new;
				var_q <= {var_q[6:4], var_q[3] + t1, var_q[2:0], t1 + t2};
				ridx_q <= ridx_q + 1'b1;
			end
			if (state_q == ST_UPDATE) begin
				if (pad_q == 2'd3 && len_lo_q) begin
					out_q.digest_0 <= {hash_q[0] + var_q[0], hash_q[1] + var_q[1]};
					out_q.digest_1 <= {hash_q[2] + var_q[2], hash_q[3] + var_q[3]};
					out_q.digest_2 <= {hash_q[4] + var_q[4], hash_q[5] + var_q[5]};
					out_q.digest_3 <= {hash_q[6] + var_q[6], hash_q[7] + var_q[7]};
					hash_q   <= INIT_HASH;
					bytes_q  <= '0;
					pad_q    <= 2'd0;
					len_lo_q <= 1'b0;
				end else begin
					for (int i = 0; i < 8; i++)
						hash_q[i] <= hash_q[i] + var_q[i];
				end
			end
		end
	end

endmodule

// ===== tb/sha256_checker.sv =====
// Digest checker for sha256_hash: watches both channels, computes the expected
// digest of every message from the accepted words, compares results in order.
// Depends on sha_pkg for the item types.
module sha256_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_stall,
	input  sha_pkg::sha_in_t  in_item,
	input  logic              out_valid,
	input  logic              out_stall,
	input  sha_pkg::sha_out_t out_item,
	output int                errors,
	output int                pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sha_pkg::*;

	localparam logic [31:0] IV [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
		32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
	localparam logic [31:0] KTAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
		32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
		32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
		32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
		32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	logic [31:0] hv [8];
	logic [31:0] blk [16];
	int unsigned fill;
	logic [60:0] nbytes;
	sha_out_t digests_due [$];

	function automatic logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
		for (int i = 0; i < 64; i++)
			if (i < 16) w[i] = blk[i];
			else w[i] = w[i-16] + w[i-7]
				+ (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10));
		a = hv[0]; b = hv[1]; c = hv[2]; d = hv[3];
		e = hv[4]; f = hv[5]; g = hv[6]; h = hv[7];
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ KTAB[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		hv[0] += a; hv[1] += b; hv[2] += c; hv[3] += d;
		hv[4] += e; hv[5] += f; hv[6] += g; hv[7] += h;
	endtask

	task automatic push(logic [31:0] w);
		blk[fill] = w;
		fill = (fill + 1) % 16;
		if (fill == 0) compress();
	endtask

	task automatic absorb(sha_in_t it);
		int unsigned nb;
		logic [63:0] bits;
		logic [31:0] keep;
		sha_out_t d;
		if (!it.last_word) begin
			nbytes += 4;
			push(it.msg_word);
			return;
		end
		nb = (it.word_bytes > 4) ? 4 : it.word_bytes;
		nbytes += nb;
		if (nb == 4) begin
			push(it.msg_word);
			push(32'h8000_0000);
		end else begin
			keep = (nb == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * nb));
			push((it.msg_word & keep) | (32'h80 << (24 - 8 * nb)));
		end
		while (fill != 14) push(32'h0);
		bits = {nbytes, 3'b000};
		push(bits[63:32]);
		push(bits[31:0]);
		d.digest_0 = {hv[0], hv[1]};
		d.digest_1 = {hv[2], hv[3]};
		d.digest_2 = {hv[4], hv[5]};
		d.digest_3 = {hv[6], hv[7]};
		digests_due.push_back(d);
		hv = IV;
		fill = 0;
		nbytes = '0;
	endtask

	assign pending = digests_due.size();

	always @(posedge clk) begin
		sha_out_t exp_d;
		if (!arst_n) begin
			errors = 0;
			hv = IV;
			fill = 0;
			nbytes = '0;
			digests_due.delete();
		end else begin
			if (in_valid && !in_stall) absorb(in_item);
			if (out_valid && !out_stall) begin
				if (digests_due.size() == 0) begin
					$display("%0t: unexpected digest %h", $time, out_item);
					errors++;
				end else begin
					exp_d = digests_due.pop_front();
					if (exp_d.digest_0 !== out_item.digest_0) begin
						$display("%0t: digest_0 exp %h got %h", $time, exp_d.digest_0,
							out_item.digest_0);
						errors++;
					end
					if (exp_d.digest_1 !== out_item.digest_1) begin
						$display("%0t: digest_1 exp %h got %h", $time, exp_d.digest_1,
							out_item.digest_1);
						errors++;
					end
					if (exp_d.digest_2 !== out_item.digest_2) begin
						$display("%0t: digest_2 exp %h got %h", $time, exp_d.digest_2,
							out_item.digest_2);
						errors++;
					end
					if (exp_d.digest_3 !== out_item.digest_3) begin
						$display("%0t: digest_3 exp %h got %h", $time, exp_d.digest_3,
							out_item.digest_3);
						errors++;
					end
				end
			end
		end
	end
endmodule

// ===== tb/tb_top.sv =====
// Top of the sha256_hash testbench: clock, reset, message stimulus with random
// idling on both sides, watchdog and verdict. Depends on sha_pkg, sha256_hash, sha256_checker.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sha_pkg::*;

	localparam int WATCHDOG = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sha_in_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sha_out_t out_item;
	int errors;
	int pending;
	bit calm = 1'b0;
	bit hold_long = 1'b0;
	int quiet = 0;

	always #1 clk = ~clk;

	sha256_hash i_dut (.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.out_valid, .out_stall, .out_item);

	sha256_checker i_chk (.clk, .arst_n, .in_valid, .in_stall, .in_item,
		.out_valid, .out_stall, .out_item, .errors, .pending);

	task automatic send_word(logic [31:0] w, logic [2:0] nb, logic lst);
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{msg_word: w, word_bytes: nb, last_word: lst};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_msg(int unsigned nwords, logic [2:0] tail);
		for (int i = 0; i < nwords; i++)
			send_word($urandom(), 3'($urandom_range(0, 7)), 1'b0);
		send_word($urandom(), tail, 1'b1);
	endtask

	// receiver side: random stall bursts, one long hold-off
	always @(negedge clk) begin
		if (hold_long) out_stall <= 1'b1;
		else if (calm) out_stall <= 1'b0;
		else if (out_stall) out_stall <= ($urandom_range(0, 3) != 0);
		else out_stall <= ($urandom_range(0, 7) == 0);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WATCHDOG) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned sent;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed: empty message, every tail length, extremes, block edges
		send_word(32'h0, 3'd0, 1'b1);
		send_word(32'hffff_ffff, 3'd0, 1'b1);
		for (int nb = 1; nb <= 7; nb++) send_word(32'hffff_ffff, nb[2:0], 1'b1);
		send_word(32'h6162_6300, 3'd3, 1'b1);
		send_msg(13, 3'd4);
		send_msg(14, 3'd3);
		send_msg(15, 3'd4);
		send_msg(15, 3'd0);
		send_word(32'h0, 3'd4, 1'b1);
		// long receiver hold-off while words keep coming
		fork
			begin
				hold_long = 1'b1;
				repeat (400) @(negedge clk);
				hold_long = 1'b0;
			end
			for (int k = 0; k < 3; k++) send_msg($urandom_range(0, 5), 3'd2);
		join
		sent = 40;
		while (sent < 1150) begin
			int unsigned n;
			if (sent > 1000) calm = 1'b1;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 48)
				: $urandom_range(0, 20);
			send_msg(n, 3'($urandom_range(0, 7)));
			sent += n + 1;
		end
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule

// ===== sim.f =====
design/sha_pkg.sv
design/sha256_hash.sv
tb/sha256_checker.sv
tb/tb_top.sv
